// ===== hdl/cbm_pkg.sv =====
// Package for the cartridge bank mapper: access codes, register indexes,
// widths, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

  localparam int CHR_WINDOWS = 8;
  localparam int CHR_WIN_W   = $clog2(CHR_WINDOWS);

  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int MAP_W       = 18;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  localparam int PRG_REG_W   = 5;
  localparam int CHR_REG_W   = 6;
  localparam int REM_W       = 5;
  localparam int DIV_W       = 6;
  localparam int STEP_W      = 3;

  localparam logic [PRG_REG_W-1:0] PRG_BANKS_RST = 5'd8;
  localparam logic [CHR_REG_W-1:0] CHR_BANKS_RST = 6'd16;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANKS = 2'd1;

  // CPU write register pages, address bits 15..12
  localparam logic [3:0] PG_PRG0      = 4'h8;
  localparam logic [3:0] PG_MIRR      = 4'h9;
  localparam logic [3:0] PG_PRG1      = 4'hA;
  localparam logic [3:0] PG_CHR_FIRST = 4'hB;
  localparam logic [3:0] PG_CHR_LAST  = 4'hE;

  typedef enum logic [1:0] {
    FUNC_CPU_RD = 2'd0,
    FUNC_CPU_WR = 2'd1,
    FUNC_PPU_RD = 2'd2,
    FUNC_PPU_WR = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_COMMIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic commit;
    logic push;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div;
    logic div_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/cbm_ctrl.sv =====
// Controller of the cartridge bank mapper: sequences one item through
// start, bank reduction and commit (bank writes only), then output load. Uses cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire                out_tready,
  input  cbm_pkg::ctrl_sts_t sts,
  output cbm_pkg::ctrl_cmd_t cmd
);

  cbm_pkg::state_t state_r, state_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic            out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == cbm_pkg::ST_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cbm_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    case (state_r)
      cbm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = cbm_pkg::ST_START;
        end
      end
      cbm_pkg::ST_START: begin
        cmd.start = 1'b1;
        state_nxt = sts.needs_div ? cbm_pkg::ST_DIV : cbm_pkg::ST_PUSH;
      end
      cbm_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = cbm_pkg::ST_COMMIT;
      end
      cbm_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = cbm_pkg::ST_PUSH;
      end
      cbm_pkg::ST_PUSH: begin
        if (out_free) begin
          cmd.push       = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = cbm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cbm_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cbm_datapath.sv =====
// Datapath of the cartridge bank mapper: config and bank registers,
// restoring remainder unit, address mapping and output register. Uses cbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbm_datapath (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  cbm_pkg::ctrl_cmd_t                    cmd,
  output cbm_pkg::ctrl_sts_t                    sts,
  input  wire  [cbm_pkg::IN_TDATA_W-1:0]        in_tdata,
  input  wire  [1:0]                            in_tuser,
  input  wire                                   cfg_valid,
  input  wire  [cbm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire  [cbm_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic [cbm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tuser
);

  localparam int CW = cbm_pkg::CHR_WINDOWS;
  localparam int WW = cbm_pkg::CHR_WIN_W;

  // latched item
  cbm_pkg::func_t                  func_r;
  logic [cbm_pkg::ADDR_W-1:0]      addr_r;
  logic [cbm_pkg::DATA_W-1:0]      data_r;

  // configuration
  logic [cbm_pkg::PRG_REG_W-1:0]   prg_banks_r;
  logic [cbm_pkg::CHR_REG_W-1:0]   chr_banks_r;

  // mapper state
  logic [4:0]                      prg0_r, prg1_r;
  logic [1:0]                      mirr_r;
  logic [3:0]                      chr_lo_r   [CW];
  logic [3:0]                      chr_hi_r   [CW];
  logic [7:0]                      chr_bank_r [CW];

  // remainder unit
  logic [cbm_pkg::REM_W-1:0]       rem_r, rem_nxt;
  logic [cbm_pkg::DIV_W-1:0]       div_r;
  logic [cbm_pkg::STEP_W-1:0]      step_r;
  logic [10:0]                     div_shl;

  // output register
  logic                            hit_r;
  logic [cbm_pkg::MAP_W-1:0]       map_r;
  logic [1:0]                      mode_r;

  logic [3:0]                      page;
  logic [3:0]                      pg_off;
  logic [WW-1:0]                   wr_win;
  logic                            is_cpu_wr, pg_chr, pg_prg;
  logic [4:0]                      prg_n;
  logic [5:0]                      prg_count;
  logic [5:0]                      chr_k;
  logic [7:0]                      full;
  logic                            hit_c;
  logic [cbm_pkg::MAP_W-1:0]       map_c;
  logic [4:0]                      cpu_bank;
  logic [WW-1:0]                   rd_win;

  assign page      = addr_r[15:12];
  assign pg_off    = page - cbm_pkg::PG_CHR_FIRST;
  assign wr_win    = {pg_off[WW-2:0], addr_r[1]};
  assign is_cpu_wr = (func_r == cbm_pkg::FUNC_CPU_WR);
  assign pg_chr    = (page >= cbm_pkg::PG_CHR_FIRST) && (page <= cbm_pkg::PG_CHR_LAST);
  assign pg_prg    = (page == cbm_pkg::PG_PRG0) || (page == cbm_pkg::PG_PRG1);

  assign sts.needs_div = is_cpu_wr && (pg_prg || pg_chr);
  assign sts.div_last  = (step_r == '0);

  always_comb begin
    if (prg_banks_r == '0)        prg_n = 5'd1;
    else if (prg_banks_r > 5'd16) prg_n = 5'd16;
    else                          prg_n = prg_banks_r;
    prg_count = {prg_n, 1'b0};
    if (chr_banks_r == '0)        chr_k = 6'd1;
    else if (chr_banks_r > 6'd32) chr_k = 6'd32;
    else                          chr_k = chr_banks_r;
  end

  // bank number with this item's nibble in place
  always_comb begin
    if (addr_r[0]) full = {data_r[3:0], chr_lo_r[wr_win]};
    else           full = {chr_hi_r[wr_win], data_r[3:0]};
  end

  assign div_shl = {5'd0, div_r} << step_r;

  always_comb begin
    rem_nxt = rem_r;
    if ({6'd0, rem_r} >= div_shl) rem_nxt = rem_r - div_shl[4:0];
  end

  // result of the latched item against the current state
  assign rd_win = addr_r[12:10];

  always_comb begin
    case (addr_r[14:13])
      2'd0:    cpu_bank = prg0_r;
      2'd1:    cpu_bank = prg1_r;
      2'd2:    cpu_bank = 5'(prg_count - 6'd2);
      default: cpu_bank = 5'(prg_count - 6'd1);
    endcase
    hit_c = 1'b0;
    map_c = '0;
    case (func_r)
      cbm_pkg::FUNC_CPU_RD: begin
        if (addr_r[15]) begin
          hit_c = 1'b1;
          map_c = {cpu_bank, addr_r[12:0]};
        end
      end
      cbm_pkg::FUNC_PPU_RD: begin
        if (addr_r[15:13] == 3'd0) begin
          hit_c = 1'b1;
          map_c = {chr_bank_r[rd_win], addr_r[9:0]};
        end
      end
      cbm_pkg::FUNC_PPU_WR: begin
        if (addr_r[15:13] == 3'd0 && chr_banks_r == '0) begin
          hit_c = 1'b1;
          map_c = {chr_bank_r[rd_win], addr_r[9:0]};
        end
      end
      default: begin
        hit_c = 1'b0;
        map_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= cbm_pkg::func_t'(in_tuser);
      addr_r <= in_tdata[15:0];
      data_r <= in_tdata[23:16];
    end
    if (cmd.start) begin
      rem_r  <= pg_chr ? full[7:3] : data_r[4:0];
      div_r  <= pg_chr ? chr_k : prg_count;
      step_r <= 3'd4;
    end else if (cmd.step) begin
      rem_r  <= rem_nxt;
      step_r <= step_r - 3'd1;
    end
    if (cmd.push) begin
      hit_r  <= hit_c;
      map_r  <= map_c;
      mode_r <= mirr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_banks_r <= cbm_pkg::PRG_BANKS_RST;
      chr_banks_r <= cbm_pkg::CHR_BANKS_RST;
      prg0_r      <= 5'd0;
      prg1_r      <= 5'd1;
      mirr_r      <= 2'd0;
      for (int i = 0; i < CW; i++) begin
        chr_lo_r[i]   <= '0;
        chr_hi_r[i]   <= '0;
        chr_bank_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_index == cbm_pkg::CFG_PRG_BANKS)
        prg_banks_r <= cfg_data[4:0];
      if (cfg_valid && cfg_index == cbm_pkg::CFG_CHR_BANKS)
        chr_banks_r <= cfg_data;
      if (cmd.start && is_cpu_wr) begin
        if (page == cbm_pkg::PG_MIRR) mirr_r <= data_r[1:0];
        if (pg_chr) begin
          if (addr_r[0]) chr_hi_r[wr_win] <= data_r[3:0];
          else           chr_lo_r[wr_win] <= data_r[3:0];
        end
      end
      if (cmd.commit) begin
        if (page == cbm_pkg::PG_PRG0) prg0_r <= rem_r;
        if (page == cbm_pkg::PG_PRG1) prg1_r <= rem_r;
        if (pg_chr) chr_bank_r[wr_win] <= {rem_r, chr_lo_r[wr_win][2:0]};
      end
    end
  end

  assign out_tdata = {4'd0, mode_r, map_r};
  assign out_tuser = hit_r;

endmodule

`default_nettype wire

// ===== hdl/cartridge_bank_mapper.sv =====
// Top level of the cartridge bank mapper: controller plus datapath.
// Depends on cbm_pkg, cbm_ctrl and cbm_datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_tvalid/in_tready  tdata {write_data, address}, tuser func
//   out_     output     out_tvalid/out_tready tdata {pad, mirror_mode, mapped_address},
//                                            tuser hit
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Reads and non-bank writes skip the remainder unit; PRG or CHR bank writes
// pass through the 5-step shared remainder unit.
// One item is worked at a time; a new item is taken while a result waits.
// A stalled output holds the next result in the datapath until taken.
// Synchronous reset restores the bank, mirroring and config registers.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_bank_mapper (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [cbm_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] address, [23:16] write_data
  input  wire  [1:0]                         in_tuser,   // [1:0] func
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [cbm_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [17:0] mapped_address, [19:18] mirror_mode
  output logic                               out_tuser,  // [0] hit
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cbm_pkg::ctrl_cmd_t cmd;
  cbm_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  cbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  cbm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

// ===== bench/cbm_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the cartridge bank mapper: follows size register writes and
// accepted accesses, predicts every result and compares it with the out_ stream.
// Depends on cbm_pkg.

module cbm_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  input  wire                             in_tready,
  input  wire  [cbm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] address, [23:16] write_data
  input  wire  [1:0]                      in_tuser,   // [1:0] func
  input  wire                             out_tvalid,
  input  wire                             out_tready,
  input  wire  [cbm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [17:0] mapped_address, [19:18] mirror_mode
  input  wire                             out_tuser,  // [0] hit
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire  [cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [cbm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              in_flight
);
  import cbm_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [MAP_W-1:0] offset;
    logic [1:0]       mirror;
  } map_result_t;

  logic [PRG_REG_W-1:0] prg_size;
  logic [CHR_REG_W-1:0] chr_size;
  logic [4:0]           prg_win0;
  logic [4:0]           prg_win1;
  logic [1:0]           mirr;
  logic [3:0]           chr_lo   [CHR_WINDOWS];
  logic [3:0]           chr_hi   [CHR_WINDOWS];
  logic [7:0]           chr_bank [CHR_WINDOWS];
  map_result_t          awaited [$];
  int                   errs = 0;

  // 8 KB program banks, 2..32
  function automatic int prg_count_8k();
    int n;
    n = prg_size;
    if (n == 0) n = 1;
    if (n > 16) n = 16;
    return 2 * n;
  endfunction

  // 1 KB graphics banks, RAM counts as 8
  function automatic int chr_count_1k();
    int n;
    n = chr_size;
    if (n > 32) n = 32;
    return (n == 0) ? 8 : 8 * n;
  endfunction

  function automatic void apply_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    logic [3:0] page;
    int         v;
    int         w;
    int         full;
    page = a[15:12];
    v = d[4:0];
    if (page == PG_PRG0) begin
      prg_win0 = 5'(v % prg_count_8k());
    end else if (page == PG_MIRR) begin
      mirr = d[1:0];
    end else if (page == PG_PRG1) begin
      prg_win1 = 5'(v % prg_count_8k());
    end else if (page >= PG_CHR_FIRST && page <= PG_CHR_LAST) begin
      w = (int'(page) - int'(PG_CHR_FIRST)) * 2 + a[1];
      if (a[0]) chr_hi[w] = d[3:0];
      else chr_lo[w] = d[3:0];
      full = {chr_hi[w], chr_lo[w]};
      chr_bank[w] = 8'(full % chr_count_1k());
    end
  endfunction

  function automatic map_result_t predict_access(func_t f, logic [ADDR_W-1:0] a,
                                                 logic [DATA_W-1:0] d);
    map_result_t r;
    logic [4:0]  bank;
    r = '0;
    case (f)
      FUNC_CPU_RD: begin
        if (a[15]) begin
          if (!a[14]) bank = a[13] ? prg_win1 : prg_win0;
          else bank = 5'(prg_count_8k() - (a[13] ? 1 : 2));
          r.hit = 1'b1;
          r.offset = {bank, a[12:0]};
        end
      end
      FUNC_CPU_WR: apply_write(a, d);
      FUNC_PPU_RD: begin
        if (a < 16'h2000) begin
          r.hit = 1'b1;
          r.offset = {chr_bank[a[12:10]], a[9:0]};
        end
      end
      default: begin
        if (a < 16'h2000 && chr_size == 0) begin
          r.hit = 1'b1;
          r.offset = {chr_bank[a[12:10]], a[9:0]};
        end
      end
    endcase
    r.mirror = mirr;
    return r;
  endfunction

  always @(posedge clk) begin : track
    map_result_t want;
    map_result_t got;
    if (!rst_n) begin
      prg_size = PRG_BANKS_RST;
      chr_size = CHR_BANKS_RST;
      prg_win0 = 5'd0;
      prg_win1 = 5'd1;
      mirr = 2'd0;
      for (int i = 0; i < CHR_WINDOWS; i++) begin
        chr_lo[i] = 4'd0;
        chr_hi[i] = 4'd0;
        chr_bank[i] = 8'd0;
      end
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PRG_BANKS) prg_size = cfg_data[PRG_REG_W-1:0];
        else if (cfg_index == CFG_CHR_BANKS) chr_size = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        got.hit = out_tuser;
        got.offset = out_tdata[MAP_W-1:0];
        got.mirror = out_tdata[MAP_W+1:MAP_W];
        if (awaited.size() == 0) begin
          if (errs < 10)
            $display("%0t: result with no access pending: hit %0d map %05h mirror %0d",
                     $realtime, got.hit, got.offset, got.mirror);
          errs++;
        end else begin
          want = awaited.pop_front();
          if (want.hit !== got.hit || want.offset !== got.offset ||
              want.mirror !== got.mirror) begin
            if (errs < 10)
              $display("%0t: mismatch: expected hit %0d map %05h mirror %0d, %s %0d %s %05h %s %0d",
                       $realtime, want.hit, want.offset, want.mirror,
                       "got hit", got.hit, "map", got.offset, "mirror", got.mirror);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited.push_back(predict_access(func_t'(in_tuser), in_tdata[ADDR_W-1:0],
                                         in_tdata[ADDR_W+DATA_W-1:ADDR_W]));
    end
    mismatches <= errs;
    in_flight <= awaited.size();
  end

endmodule

// ===== bench/cartridge_bank_mapper_tb.sv =====
`timescale 1ns / 1ps
// Top of the cartridge bank mapper bench: clock, reset, access and size
// register stimulus, result back-pressure and the verdict.
// Depends on cbm_pkg, cartridge_bank_mapper and cbm_checker.

module cartridge_bank_mapper_tb;
  import cbm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  wire                    in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] out_tdata;
  wire                    out_tuser;
  logic                   cfg_valid = 1'b0;
  wire                    cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     mismatches;
  int                     in_flight;

  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int sink_hold = 0;

  cartridge_bank_mapper uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cbm_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result sink: random stalls per item, plus an occasional long hold-off
  initial begin : sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      gap = sink_stalls ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic issue_access(func_t f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    int gap;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, a};
    in_tuser <= f;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering, wait for every result, then let the block go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_size_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_sizes(logic [CFG_DATA_W-1:0] prg, logic [CFG_DATA_W-1:0] chr,
                            bit stray);
    settle();
    write_size_reg(CFG_PRG_BANKS, prg);
    write_size_reg(CFG_CHR_BANKS, chr);
    if (stray) begin
      write_size_reg(CFG_SPARE_LO, 6'($urandom));
      write_size_reg(CFG_SPARE_HI, 6'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly register writes and in-range reads, some stray addresses
  task automatic random_access();
    func_t             f;
    logic [ADDR_W-1:0] a;
    logic [DATA_W-1:0] d;
    int                pick;
    d = 8'($urandom);
    a = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      f = FUNC_CPU_WR;
      if ($urandom_range(0, 9) < 8) a = 16'($urandom_range(16'h8000, 16'hEFFF));
    end else if (pick < 60) begin
      f = FUNC_CPU_RD;
      if ($urandom_range(0, 9) < 8) a[15] = 1'b1;
    end else begin
      f = (pick < 85) ? FUNC_PPU_RD : FUNC_PPU_WR;
      if ($urandom_range(0, 9) < 8) a[15:13] = 3'b000;
    end
    issue_access(f, a, d);
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] prg;
    logic [CFG_DATA_W-1:0] chr;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset banks, then the PRG, mirroring and first and last CHR pages and the no-hit corners
    issue_access(FUNC_CPU_RD, 16'h0000, 8'hFF);
    issue_access(FUNC_CPU_RD, 16'h7FFF, 8'h00);
    issue_access(FUNC_CPU_RD, 16'h8000, 8'h00);
    issue_access(FUNC_CPU_RD, 16'hA123, 8'h00);
    issue_access(FUNC_CPU_RD, 16'hC000, 8'h00);
    issue_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
    issue_access(FUNC_PPU_RD, 16'h1FFF, 8'h00);
    issue_access(FUNC_PPU_RD, 16'h2000, 8'h00);
    issue_access(FUNC_PPU_WR, 16'h0400, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'h8000, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'h9FFF, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'hA000, 8'h11);
    issue_access(FUNC_CPU_WR, 16'hB000, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'hB001, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'hEFFF, 8'hA5);
    issue_access(FUNC_CPU_WR, 16'hEFFE, 8'h5A);
    issue_access(FUNC_CPU_WR, 16'hF000, 8'hFF);
    issue_access(FUNC_CPU_WR, 16'h7FFF, 8'h00);
    issue_access(FUNC_CPU_RD, 16'h9FFF, 8'h00);
    issue_access(FUNC_CPU_RD, 16'hBFFF, 8'h00);
    issue_access(FUNC_PPU_RD, 16'h0000, 8'h00);
    issue_access(FUNC_PPU_RD, 16'h1C00, 8'h00);
    issue_access(FUNC_PPU_WR, 16'hFFFF, 8'hFF);
    // graphics RAM: writes now map
    load_sizes(6'd1, 6'd0, 1'b1);
    issue_access(FUNC_PPU_WR, 16'h03FF, 8'h00);
    issue_access(FUNC_PPU_WR, 16'h2000, 8'h00);

    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin prg = 6'd1;  chr = 6'd0;  end
        1: begin prg = 6'd16; chr = 6'd32; end
        2: begin prg = 6'd0;  chr = 6'd63; end
        3: begin prg = 6'd63; chr = 6'd1;  end
        4: begin prg = 6'd5;  chr = 6'd0;  end
        5: begin prg = 6'd17; chr = 6'd33; end
        6: begin prg = 6'd2;  chr = 6'd8;  end
        default: begin
          prg = 6'($urandom);
          chr = 6'($urandom);
        end
      endcase
      load_sizes(prg, chr, k % 3 == 0);
      src_gaps = (k != 0) && ($urandom_range(0, 3) != 0);
      sink_stalls = (k != 0) && ($urandom_range(0, 3) != 0);
      if (k == 3) begin
        // back-pressure: sink holds off while items keep coming
        src_gaps = 1'b0;
        sink_hold = 300;
      end
      for (int i = 0; i < 200; i++) begin
        if (k == 5 && i == 100) settle();
        random_access();
      end
    end

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
